// File: src/perf_monitor_counter_unit_core_macros.svh
// Assertion macros shared by the performance monitor RTL.
// No dependencies; defining ASSERT_OFF compiles every check away.
`ifndef PERF_MONITOR_COUNTER_UNIT_CORE_MACROS_SVH
`define PERF_MONITOR_COUNTER_UNIT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, off while reset is low
`define PMCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off while reset is low
`define PMCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PMCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PMCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/pmcu_pkg.sv
// Shared types, constants and helpers of the performance monitor unit.
// No dependencies; every RTL module imports this package.
package pmcu_pkg;

    localparam int NUM_EVENT_COUNTERS = 4;
    localparam int EVENTS_PER_TICK    = 2;
    // The request carries two event code slots
    localparam int NUM_CODES = (EVENTS_PER_TICK < 2) ? EVENTS_PER_TICK : 2;
    localparam int ADD_W     = $clog2(NUM_CODES + 1);
    localparam int SEL_W     = (NUM_EVENT_COUNTERS > 1) ? $clog2(NUM_EVENT_COUNTERS) : 1;
    localparam int MASK_W    = NUM_EVENT_COUNTERS + 1;
    localparam int CYC_LANE  = NUM_EVENT_COUNTERS;
    localparam int CYC_BIT   = 31;

    localparam logic [7:0] NO_EVENT = 8'hFF;

    // Control register bit positions
    localparam int CTRL_ENABLE_BIT   = 0;
    localparam int CTRL_EVRESET_BIT  = 1;
    localparam int CTRL_CYCRESET_BIT = 2;
    localparam int CTRL_DIV64_BIT    = 3;

    // Request function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Register indexes
    localparam logic [3:0] REG_CTRL   = 4'd0;
    localparam logic [3:0] REG_ENSET  = 4'd1;
    localparam logic [3:0] REG_ENCLR  = 4'd2;
    localparam logic [3:0] REG_OVF    = 4'd3;
    localparam logic [3:0] REG_SEL    = 4'd4;
    localparam logic [3:0] REG_EVTYPE = 4'd5;
    localparam logic [3:0] REG_CYC    = 4'd6;
    localparam logic [3:0] REG_EVCNT  = 4'd7;
    localparam logic [3:0] REG_INTSET = 4'd8;
    localparam logic [3:0] REG_INTCLR = 4'd9;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [7:0]  event_a;
        logic [7:0]  event_b;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } t_rsp;

    typedef struct packed {
        logic tick;
        logic clear;
        logic wr_type;
        logic wr_count;
    } t_lane_ctl;

    typedef struct packed {
        logic [7:0]  ev_type;
        logic [31:0] count;
        logic        ovf;
    } t_lane_stat;

    typedef struct packed {
        logic tick;
        logic div;
        logic clear;
        logic wr;
    } t_cyc_ctl;

    // Map a 32-bit register word onto the implemented counter mask bits
    function automatic logic [MASK_W-1:0] mask_from_word(input logic [31:0] w);
        return {w[CYC_BIT], w[NUM_EVENT_COUNTERS-1:0]};
    endfunction

    // Spread the implemented counter mask bits over a register word
    function automatic logic [31:0] word_from_mask(input logic [MASK_W-1:0] m);
        logic [31:0] w;
        w = '0;
        w[NUM_EVENT_COUNTERS-1:0] = m[NUM_EVENT_COUNTERS-1:0];
        w[CYC_BIT] = m[CYC_LANE];
        return w;
    endfunction

endpackage

// File: src/pmcu_lane.sv
// One event counter lane: event type, 32-bit count, match and overflow.
// Depends on pmcu_pkg.
module pmcu_lane
    import pmcu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_lane_ctl       i_ctl,
    input  logic [1:0][7:0] i_codes,
    input  logic [31:0]     i_wdata,
    output t_lane_stat      o_stat
);

    logic [7:0]       r_type;
    logic [31:0]      r_count;
    logic [ADD_W-1:0] w_add;
    logic [32:0]      w_sum;

    // Count matching event codes and form the new count with carry
    always_comb begin
        w_add = '0;
        for (int k = 0; k < NUM_CODES; k++) begin
            if (i_codes[k] != NO_EVENT && i_codes[k] == r_type) begin
                w_add = w_add + ADD_W'(1);
            end
        end
        w_sum = {1'b0, r_count} + {{(33 - ADD_W){1'b0}}, w_add};
    end

    // Update type and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.wr_type) begin
                r_type <= i_wdata[7:0];
            end
            if (i_ctl.clear) begin
                r_count <= '0;
            end else if (i_ctl.wr_count) begin
                r_count <= i_wdata;
            end else if (i_ctl.tick) begin
                r_count <= w_sum[31:0];
            end
        end
    end

    assign o_stat.ev_type = r_type;
    assign o_stat.count   = r_count;
    assign o_stat.ovf     = i_ctl.tick & w_sum[32];

endmodule

// File: src/pmcu_cycle.sv
// Cycle counter with its divide-by-64 prescaler and overflow detect.
// Depends on pmcu_pkg.
module pmcu_cycle
    import pmcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cyc_ctl    i_ctl,
    input  logic [31:0] i_wdata,
    output logic [31:0] o_count,
    output logic        o_ovf
);

    logic [31:0] r_count;
    logic [5:0]  r_pre;
    logic [5:0]  n_pre;
    logic        w_inc;

    // Advance the prescaler; count on its wrap when dividing
    always_comb begin
        n_pre = r_pre + 6'd1;
        w_inc = !i_ctl.div || (n_pre == 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pre   <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
            r_pre   <= '0;
        end else if (i_ctl.wr) begin
            r_count <= i_wdata;
        end else if (i_ctl.tick) begin
            if (i_ctl.div) begin
                r_pre <= n_pre;
            end
            if (w_inc) begin
                r_count <= r_count + 32'd1;
            end
        end
    end

    assign o_count = r_count;
    assign o_ovf   = i_ctl.tick & w_inc & (&r_count);

endmodule

// File: src/perf_monitor_counter_unit_core.sv
// Performance monitor top level: register file, event counter lanes,
// cycle counter, overflow merge and output buffer. Depends on pmcu_pkg,
// pmcu_lane, pmcu_cycle and perf_monitor_counter_unit_core_macros.svh.
// Response: registered in the output register, or in the skid stage while i_stall holds the output.
// Throughput: one request per clock while o_stall is low; enabled lanes update in the accept cycle.
// Reset (i_rst_n low, synchronous) clears all counters, masks and buffer valid flags.
`include "perf_monitor_counter_unit_core_macros.svh"
module perf_monitor_counter_unit_core
    import pmcu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_data
);

    t_req              w_req;
    logic              w_in_acc;
    logic              w_is_tick;
    logic              w_is_rd;
    logic              w_is_wr;
    logic              w_run;
    logic              w_sel_ok;
    logic [SEL_W-1:0]  w_sel_idx;
    logic [1:0][7:0]   w_codes;

    logic              r_enable;
    logic              r_div;
    logic [MASK_W-1:0] r_cnt_en;
    logic [MASK_W-1:0] r_ie;
    logic [MASK_W-1:0] r_ovf;
    logic [4:0]        r_sel;
    logic              n_enable;
    logic              n_div;
    logic [MASK_W-1:0] n_cnt_en;
    logic [MASK_W-1:0] n_ie;
    logic [MASK_W-1:0] n_ovf;
    logic [4:0]        n_sel;

    t_lane_ctl         w_lane_ctl  [NUM_EVENT_COUNTERS];
    t_lane_stat        w_lane_stat [NUM_EVENT_COUNTERS];
    t_cyc_ctl          w_cyc_ctl;
    logic [31:0]       w_cyc_count;
    logic              w_cyc_ovf;
    logic [MASK_W-1:0] w_ovf_set;
    logic [MASK_W-1:0] w_wmask;
    logic [31:0]       w_rd_mux;
    t_rsp              w_rsp;

    logic              r_out_valid;
    logic              r_skid_valid;
    t_rsp              r_out;
    t_rsp              r_skid;

    // Decode the request
    assign w_req     = i_data;
    assign o_stall   = r_skid_valid | !i_rst_n;
    assign w_in_acc  = i_valid & !o_stall;
    assign w_is_tick = w_in_acc && (w_req.func == FUNC_TICK);
    assign w_is_rd   = w_in_acc && (w_req.func == FUNC_READ);
    assign w_is_wr   = w_in_acc && (w_req.func == FUNC_WRITE);
    assign w_run     = w_is_tick & r_enable;
    assign w_sel_ok  = r_sel < 5'(NUM_EVENT_COUNTERS);
    assign w_sel_idx = r_sel[SEL_W-1:0];
    assign w_codes   = {w_req.event_b, w_req.event_a};
    assign w_wmask   = mask_from_word(w_req.write_data);

    // Event counter lanes
    for (genvar g = 0; g < NUM_EVENT_COUNTERS; g++) begin : g_lane
        always_comb begin
            w_lane_ctl[g].tick     = w_run & r_cnt_en[g];
            w_lane_ctl[g].clear    = w_is_wr && (w_req.reg_index == REG_CTRL)
                                     && w_req.write_data[CTRL_EVRESET_BIT];
            w_lane_ctl[g].wr_type  = w_is_wr && (w_req.reg_index == REG_EVTYPE)
                                     && w_sel_ok && (w_sel_idx == SEL_W'(g));
            w_lane_ctl[g].wr_count = w_is_wr && (w_req.reg_index == REG_EVCNT)
                                     && w_sel_ok && (w_sel_idx == SEL_W'(g));
        end

        pmcu_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_lane_ctl[g]),
            .i_codes (w_codes),
            .i_wdata (w_req.write_data),
            .o_stat  (w_lane_stat[g])
        );

        assign w_ovf_set[g] = w_lane_stat[g].ovf;
    end

    // Cycle counter
    always_comb begin
        w_cyc_ctl.tick  = w_run & r_cnt_en[CYC_LANE];
        w_cyc_ctl.div   = r_div;
        w_cyc_ctl.clear = w_is_wr && (w_req.reg_index == REG_CTRL)
                          && w_req.write_data[CTRL_CYCRESET_BIT];
        w_cyc_ctl.wr    = w_is_wr && (w_req.reg_index == REG_CYC);
    end

    pmcu_cycle u_cycle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cyc_ctl),
        .i_wdata (w_req.write_data),
        .o_count (w_cyc_count),
        .o_ovf   (w_cyc_ovf)
    );

    assign w_ovf_set[CYC_LANE] = w_cyc_ovf;

    // Merge lane overflows and apply register writes
    always_comb begin
        n_enable = r_enable;
        n_div    = r_div;
        n_cnt_en = r_cnt_en;
        n_ie     = r_ie;
        n_ovf    = r_ovf | w_ovf_set;
        n_sel    = r_sel;
        if (w_is_wr) begin
            unique case (w_req.reg_index)
                REG_CTRL: begin
                    n_enable = w_req.write_data[CTRL_ENABLE_BIT];
                    n_div    = w_req.write_data[CTRL_DIV64_BIT];
                end
                REG_ENSET:  n_cnt_en = r_cnt_en | w_wmask;
                REG_ENCLR:  n_cnt_en = r_cnt_en & ~w_wmask;
                REG_OVF:    n_ovf    = r_ovf & ~w_wmask;
                REG_SEL:    n_sel    = w_req.write_data[4:0];
                REG_INTSET: n_ie     = r_ie | w_wmask;
                REG_INTCLR: n_ie     = r_ie & ~w_wmask;
                default: ;
            endcase
        end
    end

    // Select read data from the state before the request
    always_comb begin
        unique case (w_req.reg_index)
            REG_CTRL: begin
                w_rd_mux = '0;
                w_rd_mux[CTRL_ENABLE_BIT] = r_enable;
                w_rd_mux[CTRL_DIV64_BIT]  = r_div;
            end
            REG_ENSET, REG_ENCLR:   w_rd_mux = word_from_mask(r_cnt_en);
            REG_OVF:                w_rd_mux = word_from_mask(r_ovf);
            REG_SEL:                w_rd_mux = {27'd0, r_sel};
            REG_EVTYPE:
                w_rd_mux = w_sel_ok ? {24'd0, w_lane_stat[w_sel_idx].ev_type} : 32'd0;
            REG_CYC:                w_rd_mux = w_cyc_count;
            REG_EVCNT:
                w_rd_mux = w_sel_ok ? w_lane_stat[w_sel_idx].count : 32'd0;
            REG_INTSET, REG_INTCLR: w_rd_mux = word_from_mask(r_ie);
            default:                w_rd_mux = '0;
        endcase
        w_rsp.read_data = w_is_rd ? w_rd_mux : 32'd0;
        w_rsp.irq       = |(n_ovf & n_ie);
    end

    // Hold register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_div    <= 1'b0;
            r_cnt_en <= '0;
            r_ie     <= '0;
            r_ovf    <= '0;
            r_sel    <= '0;
        end else begin
            r_enable <= n_enable;
            r_div    <= n_div;
            r_cnt_en <= n_cnt_en;
            r_ie     <= n_ie;
            r_ovf    <= n_ovf;
            r_sel    <= n_sel;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : w_rsp;
        end else if (w_in_acc) begin
            r_skid <= w_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `PMCU_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `PMCU_ASSERT_NEXT(a_ovf_hold, i_clk, i_rst_n, i_rst_n && !w_in_acc, $stable(r_ovf), "overflow flags moved without a request")
    `PMCU_ASSERT_NEXT(a_irq_fresh, i_clk, i_rst_n, w_in_acc && (!r_out_valid || !i_stall), r_out.irq == (|(r_ovf & r_ie)), "interrupt out of step with flags")
    `PMCU_ASSERT_NEXT(a_read_quiet, i_clk, i_rst_n, w_is_rd, $stable(w_cyc_count) && $stable(r_cnt_en) && $stable(r_ovf), "register read changed state")

endmodule
